/* design/ssb_pkg.sv */
// shared types, constants and widths for the seam linear blend block
// no dependencies; every other file of the block refers to this package by scoped names
package ssb_pkg;

   // widest image the blend supports; the image width taken from the register saturates here
   localparam int MAX_WIDTH = 4096;

   // field widths
   localparam int COLUMN_W  = 12;
   localparam int START_W   = 12;
   localparam int IMAGE_W_W = 13;
   localparam int PIXEL_W   = 8;
   localparam int CHANNELS  = 3;

   // arithmetic widths: span and weights, then the weighted sum
   localparam int SPAN_W     = $clog2(MAX_WIDTH + 1);
   localparam int NUM_W      = SPAN_W + PIXEL_W;
   localparam int QUO_STAGES = PIXEL_W;

   // queue between front and back (depth a power of two, pointers wrap)
   localparam int MID_DEPTH = 4;
   localparam int MID_PTR_W = $clog2(MID_DEPTH);
   localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);

   // result queue (depth a power of two, pointers wrap)
   localparam int OUT_DEPTH = 16;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   // register port
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = IMAGE_W_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_OVERLAP_START = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH   = CSR_INDEX_W'(1);
   localparam logic [START_W-1:0]     OVERLAP_START_RESET = START_W'(0);
   localparam logic [IMAGE_W_W-1:0]   IMAGE_WIDTH_RESET   = IMAGE_W_W'(4096);

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef logic [SPAN_W-1:0]  span_type;
   typedef logic [NUM_W-1:0]   num_type;

   // input transaction
   typedef struct packed {
      logic [COLUMN_W-1:0] column;
      pixel_type           base_red;
      pixel_type           base_green;
      pixel_type           base_blue;
      pixel_type           warp_red;
      pixel_type           warp_green;
      pixel_type           warp_blue;
   } req_type;

   // result transaction
   typedef struct packed {
      pixel_type out_red;
      pixel_type out_green;
      pixel_type out_blue;
   } rsp_type;

   // configuration as seen by the front
   typedef struct packed {
      logic [START_W-1:0] overlap_start;
      span_type           span_limit;
   } cfg_type;

   // classified work for the back: out = (base*wb + warp*ww) / divisor per channel
   // channel 0 is red, 1 green, 2 blue
   typedef struct packed {
      pixel_type [CHANNELS-1:0] base;
      pixel_type [CHANNELS-1:0] warp;
      span_type                 weight_base;
      span_type                 weight_warp;
      span_type                 divisor;
   } task_type;

endpackage

/* design/ssb_front.sv */
// front of the seam blend: accepts pixel pairs, classifies them and queues the work
// depends on ssb_pkg
module ssb_front (
   input  logic              clock,
   input  logic              reset,
   input  ssb_pkg::cfg_type  cfg,
   input  logic              req_push,
   output logic              req_full,
   input  ssb_pkg::req_type  req_data,
   output logic              task_valid,
   output ssb_pkg::task_type task_data,
   input  logic              task_take
);

   localparam logic [1:0] KIND_BASE  = 2'd0;
   localparam logic [1:0] KIND_WARP  = 2'd1;
   localparam logic [1:0] KIND_BLEND = 2'd2;

   logic                     empty_overlap;
   logic                     left_of_overlap;
   logic                     right_of_overlap;
   logic                     black_warp;
   logic [1:0]               kind;
   ssb_pkg::task_type        task_in;

   ssb_pkg::task_type        mem_ff [ssb_pkg::MID_DEPTH];
   logic [ssb_pkg::MID_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ssb_pkg::MID_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ssb_pkg::MID_CNT_W-1:0] count_ff, count_in;
   logic                     push_ok;
   logic                     pop_ok;

   // region of the column within the overlap
   always_comb begin
      empty_overlap    = 32'(cfg.overlap_start) >= 32'(cfg.span_limit);
      left_of_overlap  = 32'(req_data.column) < 32'(cfg.overlap_start);
      right_of_overlap = 32'(req_data.column) >= 32'(cfg.span_limit);
      black_warp       = (req_data.warp_red == '0) && (req_data.warp_green == '0)
                         && (req_data.warp_blue == '0);
      priority if (empty_overlap || left_of_overlap) begin
         kind = KIND_BASE;
      end else if (right_of_overlap) begin
         kind = KIND_WARP;
      end else if (black_warp) begin
         kind = KIND_BASE;
      end else begin
         kind = KIND_BLEND;
      end
   end

   // weights and divisor; pass cases divide by one
   always_comb begin
      task_in.base = {req_data.base_blue, req_data.base_green, req_data.base_red};
      task_in.warp = {req_data.warp_blue, req_data.warp_green, req_data.warp_red};
      unique case (kind)
         KIND_WARP: begin
            task_in.weight_base = '0;
            task_in.weight_warp = ssb_pkg::SPAN_W'(1);
            task_in.divisor     = ssb_pkg::SPAN_W'(1);
         end
         KIND_BLEND: begin
            task_in.weight_base = cfg.span_limit - ssb_pkg::SPAN_W'(req_data.column);
            task_in.weight_warp = ssb_pkg::SPAN_W'(req_data.column)
                                  - ssb_pkg::SPAN_W'(cfg.overlap_start);
            task_in.divisor     = cfg.span_limit - ssb_pkg::SPAN_W'(cfg.overlap_start);
         end
         default: begin
            task_in.weight_base = ssb_pkg::SPAN_W'(1);
            task_in.weight_warp = '0;
            task_in.divisor     = ssb_pkg::SPAN_W'(1);
         end
      endcase
   end

   // work queue control
   assign req_full   = count_ff == ssb_pkg::MID_CNT_W'(ssb_pkg::MID_DEPTH);
   assign task_valid = count_ff != '0;
   assign task_data  = mem_ff[rd_ptr_ff];
   assign push_ok    = req_push && !req_full;
   assign pop_ok     = task_take && task_valid;

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + ssb_pkg::MID_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + ssb_pkg::MID_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + ssb_pkg::MID_CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - ssb_pkg::MID_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= task_in;
      end
   end

endmodule

/* design/ssb_back.sv */
// back of the seam blend: weighted sum, pipelined restoring divider, result queue
// depends on ssb_pkg; fed by ssb_front
module ssb_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              task_valid,
   input  ssb_pkg::task_type task_data,
   output logic              task_take,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output ssb_pkg::rsp_type  rsp_data
);

   localparam int LAST = ssb_pkg::QUO_STAGES - 1;

   // credits for free result queue slots not yet claimed by work in flight
   logic [ssb_pkg::OUT_CNT_W-1:0] credit_ff, credit_in;
   logic                          issue;

   // product stage
   logic                          p_vld_ff;
   ssb_pkg::num_type              p_num_ff [ssb_pkg::CHANNELS];
   ssb_pkg::span_type             p_div_ff;
   ssb_pkg::num_type              p_num_in [ssb_pkg::CHANNELS];

   // divider stages, one quotient bit each, most significant first
   logic [ssb_pkg::QUO_STAGES-1:0] d_vld_ff;
   ssb_pkg::num_type              d_rem_ff [ssb_pkg::QUO_STAGES][ssb_pkg::CHANNELS];
   ssb_pkg::pixel_type            d_quo_ff [ssb_pkg::QUO_STAGES][ssb_pkg::CHANNELS];
   ssb_pkg::span_type             d_div_ff [ssb_pkg::QUO_STAGES];
   logic [ssb_pkg::QUO_STAGES-1:0] s_vld;
   ssb_pkg::num_type              s_rem [ssb_pkg::QUO_STAGES][ssb_pkg::CHANNELS];
   ssb_pkg::pixel_type            s_quo [ssb_pkg::QUO_STAGES][ssb_pkg::CHANNELS];
   ssb_pkg::span_type             s_div [ssb_pkg::QUO_STAGES];
   ssb_pkg::num_type              d_rem_in [ssb_pkg::QUO_STAGES][ssb_pkg::CHANNELS];
   ssb_pkg::pixel_type            d_quo_in [ssb_pkg::QUO_STAGES][ssb_pkg::CHANNELS];

   // result queue
   ssb_pkg::rsp_type              oq_mem_ff [ssb_pkg::OUT_DEPTH];
   logic [ssb_pkg::OUT_PTR_W-1:0] oq_wr_ptr_ff, oq_wr_ptr_in;
   logic [ssb_pkg::OUT_PTR_W-1:0] oq_rd_ptr_ff, oq_rd_ptr_in;
   logic [ssb_pkg::OUT_CNT_W-1:0] oq_count_ff, oq_count_in;
   logic                          oq_push;
   logic                          oq_pop;
   ssb_pkg::rsp_type              oq_wdata;

   // take work only with a result slot reserved
   assign issue     = task_valid && (credit_ff != '0);
   assign task_take = issue;

   // weighted sum per channel
   always_comb begin
      for (int c = 0; c < ssb_pkg::CHANNELS; c++) begin
         p_num_in[c] = ssb_pkg::NUM_W'(task_data.base[c])
                       * ssb_pkg::NUM_W'(task_data.weight_base)
                       + ssb_pkg::NUM_W'(task_data.warp[c])
                       * ssb_pkg::NUM_W'(task_data.weight_warp);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else begin
         p_vld_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < ssb_pkg::CHANNELS; c++) begin
         p_num_ff[c] <= p_num_in[c];
      end
      p_div_ff <= task_data.divisor;
   end

   // stage inputs: first from the product stage, then from the stage before
   always_comb begin
      s_vld[0] = p_vld_ff;
      s_div[0] = p_div_ff;
      for (int c = 0; c < ssb_pkg::CHANNELS; c++) begin
         s_rem[0][c] = p_num_ff[c];
         s_quo[0][c] = '0;
      end
      for (int s = 1; s < ssb_pkg::QUO_STAGES; s++) begin
         s_vld[s] = d_vld_ff[s-1];
         s_div[s] = d_div_ff[s-1];
         for (int c = 0; c < ssb_pkg::CHANNELS; c++) begin
            s_rem[s][c] = d_rem_ff[s-1][c];
            s_quo[s][c] = d_quo_ff[s-1][c];
         end
      end
   end

   // compare and subtract the shifted divisor
   always_comb begin
      ssb_pkg::num_type trial;
      for (int s = 0; s < ssb_pkg::QUO_STAGES; s++) begin
         for (int c = 0; c < ssb_pkg::CHANNELS; c++) begin
            trial          = ssb_pkg::NUM_W'(s_div[s]) << (LAST - s);
            d_rem_in[s][c] = s_rem[s][c];
            d_quo_in[s][c] = s_quo[s][c];
            if (s_rem[s][c] >= trial) begin
               d_rem_in[s][c]          = s_rem[s][c] - trial;
               d_quo_in[s][c][LAST - s] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= '0;
      end else begin
         d_vld_ff <= s_vld;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < ssb_pkg::QUO_STAGES; s++) begin
         d_div_ff[s] <= s_div[s];
         for (int c = 0; c < ssb_pkg::CHANNELS; c++) begin
            d_rem_ff[s][c] <= d_rem_in[s][c];
            d_quo_ff[s][c] <= d_quo_in[s][c];
         end
      end
   end

   // result queue control
   assign oq_push   = d_vld_ff[LAST];
   assign rsp_empty = oq_count_ff == '0;
   assign oq_pop    = rsp_pop && !rsp_empty;
   assign rsp_data  = oq_mem_ff[oq_rd_ptr_ff];

   always_comb begin
      oq_wdata.out_red   = d_quo_ff[LAST][0];
      oq_wdata.out_green = d_quo_ff[LAST][1];
      oq_wdata.out_blue  = d_quo_ff[LAST][2];
   end

   always_comb begin
      oq_wr_ptr_in = oq_push ? oq_wr_ptr_ff + ssb_pkg::OUT_PTR_W'(1) : oq_wr_ptr_ff;
      oq_rd_ptr_in = oq_pop ? oq_rd_ptr_ff + ssb_pkg::OUT_PTR_W'(1) : oq_rd_ptr_ff;
      oq_count_in  = oq_count_ff;
      if (oq_push && !oq_pop) begin
         oq_count_in = oq_count_ff + ssb_pkg::OUT_CNT_W'(1);
      end else if (oq_pop && !oq_push) begin
         oq_count_in = oq_count_ff - ssb_pkg::OUT_CNT_W'(1);
      end
      credit_in = credit_ff;
      if (issue && !oq_pop) begin
         credit_in = credit_ff - ssb_pkg::OUT_CNT_W'(1);
      end else if (oq_pop && !issue) begin
         credit_in = credit_ff + ssb_pkg::OUT_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ptr_ff <= '0;
         oq_rd_ptr_ff <= '0;
         oq_count_ff  <= '0;
         credit_ff    <= ssb_pkg::OUT_CNT_W'(ssb_pkg::OUT_DEPTH);
      end else begin
         oq_wr_ptr_ff <= oq_wr_ptr_in;
         oq_rd_ptr_ff <= oq_rd_ptr_in;
         oq_count_ff  <= oq_count_in;
         credit_ff    <= credit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (oq_push) begin
         oq_mem_ff[oq_wr_ptr_ff] <= oq_wdata;
      end
   end

   // every result slot is either free, in flight or holding a result
   a_credit_balance: assert property (@(posedge clock) disable iff (reset)
      32'(credit_ff) + 32'(oq_count_ff) + $countones({p_vld_ff, d_vld_ff})
      == ssb_pkg::OUT_DEPTH)
      else $error("result slot accounting broken");

   // a finished result never meets a full result queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      d_vld_ff[LAST] |-> oq_count_ff != ssb_pkg::OUT_CNT_W'(ssb_pkg::OUT_DEPTH))
      else $error("result queue overflow");

   // quotient complete: final remainder below the divisor
   a_remainder_range: assert property (@(posedge clock) disable iff (reset)
      d_vld_ff[LAST] |->
         (d_rem_ff[LAST][0] < ssb_pkg::NUM_W'(d_div_ff[LAST]))
         && (d_rem_ff[LAST][1] < ssb_pkg::NUM_W'(d_div_ff[LAST]))
         && (d_rem_ff[LAST][2] < ssb_pkg::NUM_W'(d_div_ff[LAST])))
      else $error("divider remainder out of range");

endmodule

/* design/stitch_seam_linear_blend.sv */
// top level of the seam linear blend: configuration registers, front and back
// depends on ssb_pkg, ssb_front and ssb_back
//
//   channel   ports                           transaction accepted when
//   request   req_push req_full req_data      req_push && !req_full
//   response  rsp_pop rsp_empty rsp_data      rsp_pop && !rsp_empty
//   config    csr_write_en csr_index csr_wdata csr_write_en
//
// one pixel pair per clock sustained while results are popped; the front, the
// product stage and the eight quotient-bit stages of the divider each take one
// transaction per cycle; a pair goes through the work queue, product stage, divider
// and result queue; reset is synchronous and clears the queues and pipeline valids
// and loads the register reset values; req_full rises when the four-entry work queue
// fills; the back holds work while all sixteen result slots are taken or in flight
module stitch_seam_linear_blend (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  ssb_pkg::req_type                   req_data,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output ssb_pkg::rsp_type                   rsp_data,
   input  logic                               csr_write_en,
   input  logic [ssb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ssb_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [ssb_pkg::START_W-1:0]   overlap_start_ff, overlap_start_in;
   logic [ssb_pkg::IMAGE_W_W-1:0] image_width_ff, image_width_in;
   ssb_pkg::cfg_type              cfg;
   logic                          task_valid;
   logic                          task_take;
   ssb_pkg::task_type             task_data;

   // register writes
   always_comb begin
      overlap_start_in = overlap_start_ff;
      image_width_in   = image_width_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            ssb_pkg::CSR_OVERLAP_START: begin
               overlap_start_in = csr_wdata[ssb_pkg::START_W-1:0];
            end
            ssb_pkg::CSR_IMAGE_WIDTH: begin
               image_width_in = csr_wdata[ssb_pkg::IMAGE_W_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         overlap_start_ff <= ssb_pkg::OVERLAP_START_RESET;
         image_width_ff   <= ssb_pkg::IMAGE_WIDTH_RESET;
      end else begin
         overlap_start_ff <= overlap_start_in;
         image_width_ff   <= image_width_in;
      end
   end

   // width saturated at the widest supported image
   always_comb begin
      cfg.overlap_start = overlap_start_ff;
      if (32'(image_width_ff) > ssb_pkg::MAX_WIDTH) begin
         cfg.span_limit = ssb_pkg::SPAN_W'(ssb_pkg::MAX_WIDTH);
      end else begin
         cfg.span_limit = ssb_pkg::SPAN_W'(image_width_ff);
      end
   end

   ssb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .task_valid (task_valid),
      .task_data  (task_data),
      .task_take  (task_take)
   );

   ssb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .task_valid (task_valid),
      .task_data  (task_data),
      .task_take  (task_take),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

/* tb/sv/stitch_seam_linear_blend_tb.sv */
// self-checking bench for the seam linear blend: queue-style driver and monitor,
// an in-bench blend predictor and register shadow; depends on ssb_pkg and the block
module stitch_seam_linear_blend_tb;

   localparam int HOLD_CYCLES     = 300;
   localparam int SETTLE_CYCLES   = 16;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int NUM_PHASES      = 12;
   localparam int PHASE_PAIRS     = 103;
   localparam int MAX_COLUMN      = (1 << ssb_pkg::COLUMN_W) - 1;
   localparam int MAX_START       = (1 << ssb_pkg::START_W) - 1;
   localparam int MAX_WIDTH_REG   = (1 << ssb_pkg::IMAGE_W_W) - 1;
   localparam int LAST_CSR_INDEX  = (1 << ssb_pkg::CSR_INDEX_W) - 1;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_push;
   logic                            req_full;
   ssb_pkg::req_type                req_data;
   logic                            rsp_empty;
   logic                            rsp_pop;
   ssb_pkg::rsp_type                rsp_data;
   logic                            csr_write_en;
   logic [ssb_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [ssb_pkg::CSR_DATA_W-1:0]  csr_wdata;

   // register shadow used by the predictor
   logic [ssb_pkg::START_W-1:0]     start_copy;
   logic [ssb_pkg::IMAGE_W_W-1:0]   width_copy;

   ssb_pkg::req_type pending_pairs [$];
   ssb_pkg::rsp_type blended_due [$];

   int  send_idle_pct;
   int  recv_idle_pct;
   bit  hold_request;
   int  hold_left;
   int  pairs_accepted;
   int  pixels_checked;
   int  settings_applied;
   int  error_count;

   stitch_seam_linear_blend u_top (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_data     (req_data),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // clock, period 8
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // expected blended pixel for one pixel pair under the shadowed registers
   function automatic ssb_pkg::rsp_type blend_pixel(input ssb_pkg::req_type pair);
      logic [ssb_pkg::IMAGE_W_W-1:0] limit;
      logic [31:0]                   span;
      logic [31:0]                   offset;
      logic [31:0]                   numerator;
      ssb_pkg::pixel_type            base [3];
      ssb_pkg::pixel_type            warp [3];
      ssb_pkg::pixel_type            blended [3];
      ssb_pkg::rsp_type              result;
      base  = '{pair.base_red, pair.base_green, pair.base_blue};
      warp  = '{pair.warp_red, pair.warp_green, pair.warp_blue};
      limit = (width_copy > ssb_pkg::MAX_WIDTH) ?
              ssb_pkg::IMAGE_W_W'(ssb_pkg::MAX_WIDTH) : width_copy;
      for (int c = 0; c < 3; c++) begin
         if (start_copy >= limit || pair.column < start_copy) begin
            blended[c] = base[c];
         end else if (pair.column >= limit) begin
            blended[c] = warp[c];
         end else if (warp[0] == '0 && warp[1] == '0 && warp[2] == '0) begin
            blended[c] = base[c];
         end else begin
            span       = 32'(limit) - 32'(start_copy);
            offset     = 32'(pair.column) - 32'(start_copy);
            numerator  = 32'(base[c]) * (span - offset) + 32'(warp[c]) * offset;
            blended[c] = ssb_pkg::pixel_type'(numerator / span);
         end
      end
      result.out_red   = blended[0];
      result.out_green = blended[1];
      result.out_blue  = blended[2];
      return result;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < 100) begin
         $display("blend error at %0t: %s got %0d want %0d", $time, what, got, want);
      end
      error_count++;
   endtask

   // register write at the rising edge, shadow follows the block
   task automatic write_register(input logic [ssb_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [ssb_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (index)
         ssb_pkg::CSR_OVERLAP_START: start_copy = value[ssb_pkg::START_W-1:0];
         ssb_pkg::CSR_IMAGE_WIDTH:   width_copy = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic queue_pixel(input int column, input int br, input int bg, input int bb,
                              input int wr, input int wg, input int wb);
      ssb_pkg::req_type pair;
      pair.column     = ssb_pkg::COLUMN_W'(column);
      pair.base_red   = ssb_pkg::pixel_type'(br);
      pair.base_green = ssb_pkg::pixel_type'(bg);
      pair.base_blue  = ssb_pkg::pixel_type'(bb);
      pair.warp_red   = ssb_pkg::pixel_type'(wr);
      pair.warp_green = ssb_pkg::pixel_type'(wg);
      pair.warp_blue  = ssb_pkg::pixel_type'(wb);
      pending_pairs.insert(pending_pairs.size(), pair);
   endtask

   // block idle: nothing left to send, every result back, then the latency
   task automatic wait_until_idle();
      while (pending_pairs.size() != 0 || blended_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // mostly uniform, sometimes an extreme value
   function automatic ssb_pkg::pixel_type random_channel();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return ssb_pkg::pixel_type'($urandom);
      endcase
   endfunction

   // driver: offers the oldest pending pair, predicts on each accepted transaction
   always @(posedge clock) begin
      logic offer;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            blended_due.insert(blended_due.size(), blend_pixel(pending_pairs.pop_front()));
            pairs_accepted++;
         end
         offer = pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct;
         req_push <= offer;
         if (offer) begin
            req_data <= pending_pairs[0];
         end
      end
   end

   // monitor: random pops, long hold-off on request, field checks
   always @(posedge clock) begin
      ssb_pkg::rsp_type want;
      if (reset) begin
         rsp_pop   <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (blended_due.size() == 0) begin
               report_mismatch("result with nothing expected, out_red", rsp_data.out_red, 0);
            end else begin
               want = blended_due.pop_front();
               if (rsp_data.out_red !== want.out_red)
                  report_mismatch("out_red", rsp_data.out_red, want.out_red);
               if (rsp_data.out_green !== want.out_green)
                  report_mismatch("out_green", rsp_data.out_green, want.out_green);
               if (rsp_data.out_blue !== want.out_blue)
                  report_mismatch("out_blue", rsp_data.out_blue, want.out_blue);
               pixels_checked++;
            end
         end
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= $urandom_range(99) >= recv_idle_pct;
         end
      end
   end

   // watchdog on cycles with no transaction on either side
   initial begin
      int stalled_cycles;
      stalled_cycles = 0;
      while (stalled_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
            stalled_cycles = 0;
         end else begin
            stalled_cycles++;
         end
      end
      $display("no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("stitch_seam_linear_blend: mismatch");
      $finish;
   end

   // stimulus
   initial begin
      ssb_pkg::req_type               pair;
      int                             plan_start;
      int                             plan_width;
      int                             plan_limit;
      int                             pick;
      logic [ssb_pkg::CSR_DATA_W-1:0] wdata;
      reset            = 1'b1;
      req_push         = 1'b0;
      req_data         = '0;
      rsp_pop          = 1'b0;
      csr_write_en     = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      start_copy       = ssb_pkg::OVERLAP_START_RESET;
      width_copy       = ssb_pkg::IMAGE_WIDTH_RESET;
      send_idle_pct    = 18;
      recv_idle_pct    = 87;
      hold_request     = 1'b0;
      hold_left        = 0;
      pairs_accepted   = 0;
      pixels_checked   = 0;
      settings_applied = 1;
      error_count      = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: whole row is overlap, black warp, extremes
      queue_pixel(0, 255, 255, 255, 255, 255, 255);
      queue_pixel(MAX_COLUMN, 0, 0, 0, 255, 255, 255);
      queue_pixel(2048, 255, 0, 128, 0, 255, 1);
      queue_pixel(1000, 12, 34, 56, 0, 0, 0);
      queue_pixel(MAX_COLUMN, 255, 255, 255, 255, 255, 255);
      wait_until_idle();

      // narrow overlap: left, both edges, right and black warp
      write_register(ssb_pkg::CSR_OVERLAP_START, ssb_pkg::CSR_DATA_W'(100));
      write_register(ssb_pkg::CSR_IMAGE_WIDTH, ssb_pkg::CSR_DATA_W'(356));
      settings_applied++;
      queue_pixel(99, 1, 2, 3, 200, 201, 202);
      queue_pixel(0, 255, 255, 255, 9, 9, 9);
      queue_pixel(100, 10, 20, 30, 250, 240, 230);
      queue_pixel(355, 10, 20, 30, 250, 240, 230);
      queue_pixel(356, 10, 20, 30, 250, 240, 230);
      queue_pixel(MAX_COLUMN, 40, 50, 60, 1, 2, 3);
      queue_pixel(228, 77, 88, 99, 0, 0, 0);
      queue_pixel(50, 77, 88, 99, 0, 0, 0);
      queue_pixel(228, 0, 0, 0, 255, 255, 255);
      wait_until_idle();

      // write to an unused index must leave the blend alone
      write_register(ssb_pkg::CSR_INDEX_W'($urandom_range(LAST_CSR_INDEX,
                                                           ssb_pkg::CSR_IMAGE_WIDTH + 1)),
                     ssb_pkg::CSR_DATA_W'($urandom));
      queue_pixel(228, 255, 255, 255, 1, 0, 0);
      queue_pixel(300, 128, 64, 32, 0, 0, 255);
      wait_until_idle();

      // random phases, one register setting each
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase < 4) begin
            send_idle_pct = 18;
            recv_idle_pct = 87;
         end else if (phase < 8) begin
            send_idle_pct = 87;
            recv_idle_pct = 18;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (phase)
            0: begin plan_start = 0;         plan_width = 1;                 end
            1: begin plan_start = MAX_START; plan_width = ssb_pkg::MAX_WIDTH; end
            2: begin plan_start = 0;         plan_width = ssb_pkg::MAX_WIDTH; end
            3: begin plan_start = 2000;      plan_width = MAX_WIDTH_REG;     end
            4: begin plan_start = 3000;      plan_width = 1000;              end
            5: begin plan_start = 0;         plan_width = 0;                 end
            6: begin plan_start = MAX_START; plan_width = MAX_WIDTH_REG;     end
            default: begin
               plan_start = $urandom_range(MAX_START);
               plan_width = ($urandom_range(3) == 0) ? $urandom_range(MAX_WIDTH_REG)
                            : $urandom_range(ssb_pkg::MAX_WIDTH, plan_start + 1);
            end
         endcase
         wdata = ssb_pkg::CSR_DATA_W'($urandom);
         wdata[ssb_pkg::START_W-1:0] = ssb_pkg::START_W'(plan_start);
         write_register(ssb_pkg::CSR_OVERLAP_START, wdata);
         write_register(ssb_pkg::CSR_IMAGE_WIDTH, ssb_pkg::CSR_DATA_W'(plan_width));
         if ($urandom_range(2) == 0) begin
            write_register(ssb_pkg::CSR_INDEX_W'($urandom_range(LAST_CSR_INDEX,
                                                                ssb_pkg::CSR_IMAGE_WIDTH + 1)),
                           ssb_pkg::CSR_DATA_W'($urandom));
         end
         settings_applied++;
         plan_limit = (plan_width > ssb_pkg::MAX_WIDTH) ? ssb_pkg::MAX_WIDTH : plan_width;
         if (phase == 0 || phase == 8) begin
            hold_request = 1'b1;
         end

         // mostly inside the overlap, some at its edges, the rest anywhere
         for (int n = 0; n < PHASE_PAIRS; n++) begin
            pick = $urandom_range(99);
            pair.column = ssb_pkg::COLUMN_W'($urandom);
            if (pick < 60 && plan_start < plan_limit) begin
               pair.column = ssb_pkg::COLUMN_W'($urandom_range(plan_limit - 1, plan_start));
            end else if (pick < 75) begin
               case ($urandom_range(3))
                  0:       pair.column = ssb_pkg::COLUMN_W'(plan_start - 1);
                  1:       pair.column = ssb_pkg::COLUMN_W'(plan_start);
                  2:       pair.column = ssb_pkg::COLUMN_W'(plan_limit - 1);
                  default: pair.column = ssb_pkg::COLUMN_W'(plan_limit);
               endcase
            end
            pair.base_red   = random_channel();
            pair.base_green = random_channel();
            pair.base_blue  = random_channel();
            pair.warp_red   = random_channel();
            pair.warp_green = random_channel();
            pair.warp_blue  = random_channel();
            if ($urandom_range(9) == 0) begin
               pair.warp_red   = '0;
               pair.warp_green = '0;
               pair.warp_blue  = '0;
            end
            pending_pairs.insert(pending_pairs.size(), pair);
         end
         wait_until_idle();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("%0d pixel pairs blended under %0d register settings, %0d results compared",
               pairs_accepted, settings_applied, pixels_checked);
      $display("covered left, right, empty and saturated overlap, black warp and a long hold-off");
      if (error_count == 0) begin
         $display("stitch_seam_linear_blend: match");
      end else begin
         $display("stitch_seam_linear_blend: mismatch");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/ssb_pkg.sv
design/ssb_front.sv
design/ssb_back.sv
design/stitch_seam_linear_blend.sv
tb/sv/stitch_seam_linear_blend_tb.sv
